// ----- src/fpdc_pkg.sv -----
// ----------------------------------------------------------------------------
// fpdc_pkg: shared types and constants for the formation PD wheel controller
// Fixed-point widths, register indexes, sequencer states, divider interface.
// ----------------------------------------------------------------------------
package fpdc_pkg;

  localparam int SINE_TABLE_DEPTH = 1024;
  // angle quantization: keep the top log2(depth) bits of the turn phase
  localparam int TRIG_SHIFT = 16 - $clog2(SINE_TABLE_DEPTH);
  localparam logic [15:0] PHASE_MASK = 16'(16'hFFFF << TRIG_SHIFT);

  // quarter-wave sine polynomial coefficients
  localparam logic [15:0] SIN_A = 16'd25736;
  localparam logic [14:0] SIN_B = 15'd10512;
  localparam logic [14:0] SIN_C = 15'd1160;

  localparam int MUL_AW = 36;
  localparam int MUL_BW = 18;
  localparam int ACC_W  = 56;
  localparam int NUM_W  = 59;
  localparam int MAG_W  = NUM_W - 1;
  localparam int DEN_W  = 32;
  localparam int CNT_W  = $clog2(MAG_W + 1);

  localparam logic [2:0] CFG_PROP_GAIN    = 3'd0;
  localparam logic [2:0] CFG_DERIV_GAIN   = 3'd1;
  localparam logic [2:0] CFG_WHEEL_RADIUS = 3'd2;
  localparam logic [2:0] CFG_WHEEL_BASE   = 3'd3;
  localparam logic [2:0] CFG_POINT_OFFSET = 3'd4;
  localparam logic [2:0] CFG_SAMPLE_RATE  = 3'd5;
  localparam logic [2:0] CFG_SPEED_LIMIT  = 3'd6;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SN0, S_SN1, S_SN2, S_SN3, S_SN4,
    S_GX0, S_GX1, S_GY0, S_GY1,
    S_DX, S_DY,
    S_UX0, S_UX1, S_UY0, S_UY1,
    S_V0, S_V1, S_W0, S_W1,
    S_VD, S_WL, S_DEN,
    S_DIVL, S_DWL, S_DIVR, S_DWR,
    S_FIN
  } state_t;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic [DEN_W-1:0]        den;
  } div_req_t;

  typedef struct packed {
    logic                    busy;
    logic                    done;
    logic signed [NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

// ----- src/formation_pd_wheel_speed_controller.sv -----
// ----------------------------------------------------------------------------
// formation_pd_wheel_speed_controller: leader-follower PD wheel speed control
// World goal from leader pose and offset, PD on the position error, inverse
// kinematics to two saturated wheel speeds.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------
//  in      | in_valid/in_ready  | robot, leader pose, offset (8 x 16b)
//  out     | out_valid/out_ready| left/right wheel speed, goal x/y (4 x 16b)
//  cfg     | cfg_we             | cfg_index (3b), cfg_data (16b)
//
//  Each beat runs the idle accept step, four sine passes and 17 MAC steps
//  on the one shared 36x18 multiplier, then two divides, each a start step,
//  58 serial steps and a done step, and then the finish. in_ready is high
//  only while the sequencer is idle. Reset (sync, low) restores register
//  defaults and clears the stored error. A result waiting on out_ready does
//  not block the next in beat; it stalls only the finish.
// ----------------------------------------------------------------------------
module formation_pd_wheel_speed_controller
  import fpdc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_robot_x,
  input  logic signed [15:0] in_robot_y,
  input  logic signed [15:0] in_robot_yaw,
  input  logic signed [15:0] in_leader_x,
  input  logic signed [15:0] in_leader_y,
  input  logic signed [15:0] in_leader_yaw,
  input  logic signed [15:0] in_offset_x,
  input  logic signed [15:0] in_offset_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_left_wheel_speed,
  output logic signed [15:0] out_right_wheel_speed,
  output logic signed [15:0] out_goal_x,
  output logic signed [15:0] out_goal_y,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  // config
  logic [15:0] prop_gain_r, deriv_gain_r, wheel_radius_r, wheel_base_r, point_offset_r;
  logic [13:0] sample_rate_r;
  logic [14:0] speed_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r    <= 16'd128;
      deriv_gain_r   <= 16'd128;
      wheel_radius_r <= 16'd410;
      wheel_base_r   <= 16'd2048;
      point_offset_r <= 16'd410;
      sample_rate_r  <= 14'd100;
      speed_limit_r  <= 15'd12288;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PROP_GAIN:    prop_gain_r    <= cfg_data;
        CFG_DERIV_GAIN:   deriv_gain_r   <= cfg_data;
        CFG_WHEEL_RADIUS: wheel_radius_r <= cfg_data;
        CFG_WHEEL_BASE:   wheel_base_r   <= cfg_data;
        CFG_POINT_OFFSET: point_offset_r <= cfg_data;
        CFG_SAMPLE_RATE:  sample_rate_r  <= cfg_data[13:0];
        CFG_SPEED_LIMIT:  speed_limit_r  <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  function automatic logic signed [ACC_W-1:0] rnd14(input logic signed [ACC_W-1:0] a);
    return (a + ACC_W'(8192)) >>> 14;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] a);
    if (a > ACC_W'(32767)) return 16'sh7FFF;
    if (a < -ACC_W'(32768)) return -16'sh8000;
    return a[15:0];
  endfunction

  function automatic logic signed [31:0] satu(input logic signed [ACC_W-1:0] a);
    if (a > ACC_W'(64'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (a < -ACC_W'(64'sh7FFF_FFFF)) return -32'sh7FFF_FFFF;
    return a[31:0];
  endfunction

  state_t state_r, state_nxt;

  logic signed [15:0] rx_r, ry_r, ryaw_r, lx_r, ly_r, lyaw_r, ox_r, oy_r;
  logic [1:0]         tcnt_r, tcnt_nxt;
  logic signed [15:0] trig_r [4];   // leader sin, leader cos, robot sin, robot cos
  logic signed [15:0] trig_nxt [4];
  logic [14:0]        z2_r, z2_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [15:0] gx_r, gx_nxt, gy_r, gy_nxt;
  logic signed [32:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic signed [31:0] ux_r, ux_nxt, uy_r, uy_nxt;
  logic signed [33:0] v_r, v_nxt, w_r, w_nxt;
  logic signed [49:0] vd_r, vd_nxt, wl_r, wl_nxt;
  logic signed [15:0] ql_r, ql_nxt, qr_r, qr_nxt;
  logic signed [16:0] last_x_r, last_x_nxt, last_y_r, last_y_nxt;
  logic signed [15:0] out_left_r, out_right_r, out_gx_r, out_gy_r;
  logic               out_valid_r, out_load;

  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [MUL_AW+MUL_BW-1:0] prod;
  logic signed [ACC_W-1:0] prod_ext, acc_sh, rd;

  logic signed [16:0] ex, ey;
  logic signed [17:0] ediff_x, ediff_y;
  logic [15:0]        ang, ph, dval, rval;
  logic [14:0]        zval, s_mag, in1;
  logic [15:0]        in2;
  logic signed [15:0] s_pos, s_val;
  logic signed [NUM_W-1:0] num_l, num_r, lim_s;
  logic               in_acc;

  div_req_t div_req;
  div_rsp_t div_rsp;

  fpdc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign prod     = mul_a * mul_b;
  assign prod_ext = ACC_W'(prod);
  assign acc_sh   = acc_r >>> 14;
  assign rd       = rnd14(acc_r);

  always_comb begin
    ex      = 17'(gx_r) - 17'(rx_r);
    ey      = 17'(gy_r) - 17'(ry_r);
    ediff_x = 18'(ex) - 18'(last_x_r);
    ediff_y = 18'(ey) - 18'(last_y_r);
    // trig phase for the current sine pass
    ang   = tcnt_r[1] ? ryaw_r : lyaw_r;
    ph    = (ang & PHASE_MASK) + (tcnt_r[0] ? 16'h4000 : 16'h0000);
    zval  = ph[14] ? 15'd16384 - {1'b0, ph[13:0]} : {1'b0, ph[13:0]};
    in1   = SIN_B - acc_sh[14:0];
    in2   = SIN_A - acc_sh[15:0];
    s_mag = (acc_sh > ACC_W'(16384)) ? 15'd16384 : acc_sh[14:0];
    s_pos = signed'(16'(s_mag));
    s_val = ph[15] ? -s_pos : s_pos;
    dval  = (point_offset_r == 16'd0) ? 16'd1 : point_offset_r;
    rval  = (wheel_radius_r == 16'd0) ? 16'd1 : wheel_radius_r;
    num_l = (NUM_W'(vd_r) - NUM_W'(wl_r)) <<< 8;
    num_r = (NUM_W'(vd_r) + NUM_W'(wl_r)) <<< 8;
    lim_s = NUM_W'({1'b0, speed_limit_r});
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_SN0;
      S_SN0:  state_nxt = S_SN1;
      S_SN1:  state_nxt = S_SN2;
      S_SN2:  state_nxt = S_SN3;
      S_SN3:  state_nxt = S_SN4;
      S_SN4:  state_nxt = (tcnt_r == 2'd3) ? S_GX0 : S_SN0;
      S_GX0:  state_nxt = S_GX1;
      S_GX1:  state_nxt = S_GY0;
      S_GY0:  state_nxt = S_GY1;
      S_GY1:  state_nxt = S_DX;
      S_DX:   state_nxt = S_DY;
      S_DY:   state_nxt = S_UX0;
      S_UX0:  state_nxt = S_UX1;
      S_UX1:  state_nxt = S_UY0;
      S_UY0:  state_nxt = S_UY1;
      S_UY1:  state_nxt = S_V0;
      S_V0:   state_nxt = S_V1;
      S_V1:   state_nxt = S_W0;
      S_W0:   state_nxt = S_W1;
      S_W1:   state_nxt = S_VD;
      S_VD:   state_nxt = S_WL;
      S_WL:   state_nxt = S_DEN;
      S_DEN:  state_nxt = S_DIVL;
      S_DIVL: state_nxt = S_DWL;
      S_DWL:  if (div_rsp.done) state_nxt = S_DIVR;
      S_DIVR: state_nxt = S_DWR;
      S_DWR:  if (div_rsp.done) state_nxt = S_FIN;
      S_FIN:  if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath control per step; acc holds the previous step's MAC result
  always_comb begin
    mul_a      = '0;
    mul_b      = '0;
    acc_nxt    = acc_r;
    tcnt_nxt   = tcnt_r;
    trig_nxt   = trig_r;
    z2_nxt     = z2_r;
    gx_nxt     = gx_r;
    gy_nxt     = gy_r;
    dx_nxt     = dx_r;
    dy_nxt     = dy_r;
    ux_nxt     = ux_r;
    uy_nxt     = uy_r;
    v_nxt      = v_r;
    w_nxt      = w_r;
    vd_nxt     = vd_r;
    wl_nxt     = wl_r;
    ql_nxt     = ql_r;
    qr_nxt     = qr_r;
    last_x_nxt = last_x_r;
    last_y_nxt = last_y_r;
    out_load   = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = num_l;
    div_req.den   = acc_r[DEN_W-1:0];  // d*r stays in acc through both divides
    case (state_r)
      S_IDLE: tcnt_nxt = 2'd0;
      S_SN0: begin
        mul_a = MUL_AW'(zval); mul_b = MUL_BW'(zval); acc_nxt = prod_ext;
      end
      S_SN1: begin
        z2_nxt = acc_sh[14:0];
        mul_a = MUL_AW'(acc_sh[14:0]); mul_b = MUL_BW'(SIN_C); acc_nxt = prod_ext;
      end
      S_SN2: begin
        mul_a = MUL_AW'(z2_r); mul_b = MUL_BW'(in1); acc_nxt = prod_ext;
      end
      S_SN3: begin
        mul_a = MUL_AW'(zval); mul_b = MUL_BW'(in2); acc_nxt = prod_ext;
      end
      S_SN4: begin
        trig_nxt[tcnt_r] = s_val;
        tcnt_nxt = tcnt_r + 2'd1;
      end
      S_GX0: begin
        mul_a = MUL_AW'(ox_r); mul_b = MUL_BW'(trig_r[1]); acc_nxt = prod_ext;
      end
      S_GX1: begin
        mul_a = MUL_AW'(oy_r); mul_b = MUL_BW'(trig_r[0]); acc_nxt = acc_r - prod_ext;
      end
      S_GY0: begin
        gx_nxt = sat16(ACC_W'(lx_r) + rd);
        mul_a = MUL_AW'(ox_r); mul_b = MUL_BW'(trig_r[0]); acc_nxt = prod_ext;
      end
      S_GY1: begin
        mul_a = MUL_AW'(oy_r); mul_b = MUL_BW'(trig_r[1]); acc_nxt = acc_r + prod_ext;
      end
      S_DX: begin
        gy_nxt = sat16(ACC_W'(ly_r) + rd);
        mul_a = MUL_AW'(ediff_x); mul_b = MUL_BW'(sample_rate_r); acc_nxt = prod_ext;
      end
      S_DY: begin
        dx_nxt = acc_r[32:0];
        mul_a = MUL_AW'(ediff_y); mul_b = MUL_BW'(sample_rate_r); acc_nxt = prod_ext;
      end
      S_UX0: begin
        dy_nxt = acc_r[32:0];
        last_x_nxt = ex;
        last_y_nxt = ey;
        mul_a = MUL_AW'(ex); mul_b = MUL_BW'(prop_gain_r); acc_nxt = prod_ext;
      end
      S_UX1: begin
        mul_a = MUL_AW'(dx_r); mul_b = MUL_BW'(deriv_gain_r); acc_nxt = acc_r + prod_ext;
      end
      S_UY0: begin
        ux_nxt = satu(acc_r);
        mul_a = MUL_AW'(ey); mul_b = MUL_BW'(prop_gain_r); acc_nxt = prod_ext;
      end
      S_UY1: begin
        mul_a = MUL_AW'(dy_r); mul_b = MUL_BW'(deriv_gain_r); acc_nxt = acc_r + prod_ext;
      end
      S_V0: begin
        uy_nxt = satu(acc_r);
        mul_a = MUL_AW'(ux_r); mul_b = MUL_BW'(trig_r[3]); acc_nxt = prod_ext;
      end
      S_V1: begin
        mul_a = MUL_AW'(uy_r); mul_b = MUL_BW'(trig_r[2]); acc_nxt = acc_r + prod_ext;
      end
      S_W0: begin
        v_nxt = rd[33:0];
        mul_a = MUL_AW'(uy_r); mul_b = MUL_BW'(trig_r[3]); acc_nxt = prod_ext;
      end
      S_W1: begin
        mul_a = MUL_AW'(ux_r); mul_b = MUL_BW'(trig_r[2]); acc_nxt = acc_r - prod_ext;
      end
      S_VD: begin
        w_nxt = rd[33:0];
        mul_a = MUL_AW'(v_r); mul_b = MUL_BW'(dval); acc_nxt = prod_ext;
      end
      S_WL: begin
        vd_nxt = acc_r[49:0];
        mul_a = MUL_AW'(w_r); mul_b = MUL_BW'(wheel_base_r); acc_nxt = prod_ext;
      end
      S_DEN: begin
        wl_nxt = acc_r[49:0];
        mul_a = MUL_AW'(dval); mul_b = MUL_BW'(rval); acc_nxt = prod_ext;
      end
      S_DIVL: div_req.start = 1'b1;
      S_DWL: begin
        if (div_rsp.done) begin
          if (div_rsp.quot > lim_s) ql_nxt = lim_s[15:0];
          else if (div_rsp.quot < -lim_s) ql_nxt = 16'(-lim_s);
          else ql_nxt = div_rsp.quot[15:0];
        end
      end
      S_DIVR: begin
        div_req.start = 1'b1;
        div_req.num   = num_r;
      end
      S_DWR: begin
        if (div_rsp.done) begin
          if (div_rsp.quot > lim_s) qr_nxt = lim_s[15:0];
          else if (div_rsp.quot < -lim_s) qr_nxt = 16'(-lim_s);
          else qr_nxt = div_rsp.quot[15:0];
        end
      end
      S_FIN: out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      last_x_r    <= '0;
      last_y_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_load || (out_valid_r && !out_ready);
      last_x_r    <= last_x_nxt;
      last_y_r    <= last_y_nxt;
    end
    if (in_acc) begin
      rx_r   <= in_robot_x;
      ry_r   <= in_robot_y;
      ryaw_r <= in_robot_yaw;
      lx_r   <= in_leader_x;
      ly_r   <= in_leader_y;
      lyaw_r <= in_leader_yaw;
      ox_r   <= in_offset_x;
      oy_r   <= in_offset_y;
    end
    if (out_load) begin
      out_left_r  <= ql_r;
      out_right_r <= qr_r;
      out_gx_r    <= gx_r;
      out_gy_r    <= gy_r;
    end
    tcnt_r <= tcnt_nxt;
    trig_r <= trig_nxt;
    z2_r   <= z2_nxt;
    acc_r  <= acc_nxt;
    gx_r   <= gx_nxt;
    gy_r   <= gy_nxt;
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    ux_r   <= ux_nxt;
    uy_r   <= uy_nxt;
    v_r    <= v_nxt;
    w_r    <= w_nxt;
    vd_r   <= vd_nxt;
    wl_r   <= wl_nxt;
    ql_r   <= ql_nxt;
    qr_r   <= qr_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_left_wheel_speed  = out_left_r;
  assign out_right_wheel_speed = out_right_r;
  assign out_goal_x            = out_gx_r;
  assign out_goal_y            = out_gy_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high right after an accepted beat");

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_FIN))
    else $error("result posted outside the finish step");

endmodule

// ----- src/fpdc_div.sv -----
// ----------------------------------------------------------------------------
// fpdc_div: restoring divider, signed numerator by unsigned nonzero divisor
// One quotient bit per cycle, truncates toward zero, done pulses at the end.
// ----------------------------------------------------------------------------
module fpdc_div
  import fpdc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic             neg_r, neg_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [MAG_W-1:0] q_r, q_nxt;
  logic [DEN_W:0]   trial;
  logic [NUM_W-1:0] mag;
  logic             qbit;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    qbit     = 1'b0;
    mag      = req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
    trial    = {rem_r, q_r[MAG_W-1]};
    if (req.start) begin
      neg_nxt  = req.num[NUM_W-1];
      den_nxt  = req.den;
      rem_nxt  = '0;
      q_nxt    = mag[MAG_W-1:0];
      cnt_nxt  = CNT_W'(MAG_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = DEN_W'(trial - {1'b0, den_r});
        qbit    = 1'b1;
      end else begin
        rem_nxt = trial[DEN_W-1:0];
      end
      q_nxt   = {q_r[MAG_W-2:0], qbit};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    neg_r <= neg_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  always_comb begin
    rsp.busy = busy_r;
    rsp.done = done_r;
    rsp.quot = neg_r ? -signed'({1'b0, q_r}) : signed'({1'b0, q_r});
  end

endmodule

// ----- tb/formation_pd_wheel_speed_controller_tb.sv -----
// ----------------------------------------------------------------------------
// formation_pd_wheel_speed_controller_tb: self-checking bench for the
// formation PD wheel speed controller.
// Random and directed pose beats go in through a queued driver. A predictor
// computes goal and wheel speeds per beat, and a monitor compares each result
// beat against the oldest prediction. Gain, geometry and limit settings are
// changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module formation_pd_wheel_speed_controller_tb
  import fpdc_pkg::*;
();

  typedef struct packed {
    logic signed [15:0] robot_x, robot_y, robot_yaw;
    logic signed [15:0] leader_x, leader_y, leader_yaw;
    logic signed [15:0] offset_x, offset_y;
  } pose_t;

  typedef struct packed {
    logic signed [15:0] left, right, goal_x, goal_y;
  } cmd_t;

  localparam longint ULIM = 64'sd2147483647;
  localparam int SETTLE = 400;
  localparam longint CYCLE_LIMIT = 64'd3000000;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  pose_t in_pose;
  logic signed [15:0] o_left, o_right, o_gx, o_gy;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;

  formation_pd_wheel_speed_controller uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_robot_x(in_pose.robot_x), .in_robot_y(in_pose.robot_y),
    .in_robot_yaw(in_pose.robot_yaw), .in_leader_x(in_pose.leader_x),
    .in_leader_y(in_pose.leader_y), .in_leader_yaw(in_pose.leader_yaw),
    .in_offset_x(in_pose.offset_x), .in_offset_y(in_pose.offset_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_left_wheel_speed(o_left), .out_right_wheel_speed(o_right),
    .out_goal_x(o_gx), .out_goal_y(o_gy),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of registers and error history
  longint kp, kd, rad, base, poff, rate, slim;
  longint prev_ex, prev_ey;

  pose_t pose_q[$];
  cmd_t  cmd_q[$];
  int    errors = 0;
  int    send_idle_pct, recv_idle_pct;
  int    hold_cycles = 0;
  bit    hold_req = 1'b0;
  bit    hold_ack = 1'b0;
  bit    send_pause;
  bit    in_fire = 1'b0;
  longint cycles = 0;

  function automatic longint asr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint rnd_shift(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint sine14(logic [15:0] ph);
    logic [1:0] q;
    longint f, z, z2, i1, i2, s;
    q  = ph[15:14];
    f  = ph[13:0];
    z  = q[0] ? 16384 - f : f;
    z2 = (z * z) >>> 14;
    i1 = 10512 - ((1160 * z2) >>> 14);
    i2 = 25736 - ((z2 * i1) >>> 14);
    s  = clampl((z * i2) >>> 14, 0, 16384);
    return q[1] ? -s : s;
  endfunction

  // quantize angle to the table grid
  function automatic logic [15:0] quant_phase(logic [15:0] a);
    longint idx;
    idx = (longint'(a) * SINE_TABLE_DEPTH) >> 16;
    return 16'((idx * 65536) / SINE_TABLE_DEPTH);
  endfunction

  function automatic cmd_t predict_cmd(pose_t p);
    cmd_t c;
    logic [15:0] lph, rph;
    longint lc, ls, rc, rs, gx, gy, ex, ey, dx, dy, ux, uy, v, w;
    longint r, d, den, lft, rgt;
    lph = quant_phase(p.leader_yaw);
    rph = quant_phase(p.robot_yaw);
    ls = sine14(lph); lc = sine14(lph + 16'd16384);
    rs = sine14(rph); rc = sine14(rph + 16'd16384);
    gx = clampl(longint'(p.leader_x)
                + rnd_shift(longint'(p.offset_x) * lc - longint'(p.offset_y) * ls, 14),
                -32768, 32767);
    gy = clampl(longint'(p.leader_y)
                + rnd_shift(longint'(p.offset_x) * ls + longint'(p.offset_y) * lc, 14),
                -32768, 32767);
    ex = gx - longint'(p.robot_x);
    ey = gy - longint'(p.robot_y);
    dx = (ex - prev_ex) * rate;
    dy = (ey - prev_ey) * rate;
    prev_ex = ex;
    prev_ey = ey;
    ux = clampl(kp * ex + kd * dx, -ULIM, ULIM);
    uy = clampl(kp * ey + kd * dy, -ULIM, ULIM);
    v = rnd_shift(rc * ux + rs * uy, 14);
    w = rnd_shift(rc * uy - rs * ux, 14);
    r = rad ? rad : 1;
    d = poff ? poff : 1;
    den = d * r;
    lft = clampl(((v * d - w * base) * 256) / den, -slim, slim);
    rgt = clampl(((v * d + w * base) * 256) / den, -slim, slim);
    c.left = 16'(lft); c.right = 16'(rgt);
    c.goal_x = 16'(gx); c.goal_y = 16'(gy);
    return c;
  endfunction

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) cycles <= cycles + 1;

  // input beat taken at this rising edge
  always @(posedge clk) in_fire <= rst_n && in_valid && in_ready;

  // driver: at most one assignment to in_valid per step
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_fire) begin
      // beat taken at the last rising edge
      void'(pose_q.pop_front());
      cmd_q.push_back(predict_cmd(in_pose));
      if (pose_q.size() != 0 && !send_pause && $urandom_range(99) >= send_idle_pct) begin
        in_pose <= pose_q[0];
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end else if (!in_valid && pose_q.size() != 0 && !send_pause
                 && $urandom_range(99) >= send_idle_pct) begin
      in_pose <= pose_q[0];
      in_valid <= 1'b1;
    end
  end

  // receiver stall, with an optional long hold
  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_cycles <= 3000;
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    cmd_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{o_left, o_right, o_gx, o_gy};
      if (cmd_q.size() == 0) begin
        errors = errors + 1;
        if (errors <= 10) $display("unexpected result beat %p", got);
      end else begin
        want = cmd_q.pop_front();
        if (got !== want) begin
          errors = errors + 1;
          if (errors <= 10)
            $display("mismatch: exp l=%0d r=%0d gx=%0d gy=%0d got l=%0d r=%0d gx=%0d gy=%0d",
                     want.left, want.right, want.goal_x, want.goal_y,
                     got.left, got.right, got.goal_x, got.goal_y);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pose_q.size() != 0 || in_valid || cmd_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PROP_GAIN:    kp = val;
      CFG_DERIV_GAIN:   kd = val;
      CFG_WHEEL_RADIUS: rad = val;
      CFG_WHEEL_BASE:   base = val;
      CFG_POINT_OFFSET: poff = val;
      CFG_SAMPLE_RATE:  rate = val[13:0];
      CFG_SPEED_LIMIT:  slim = val[14:0];
      default: ;
    endcase
  endtask

  function automatic logic [15:0] rnd16();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(0, 511)) - 16'd256;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic pose_t rnd_pose();
    pose_t p;
    p.robot_x = rnd16(); p.robot_y = rnd16(); p.robot_yaw = 16'($urandom);
    p.leader_x = rnd16(); p.leader_y = rnd16(); p.leader_yaw = 16'($urandom);
    p.offset_x = rnd16(); p.offset_y = rnd16();
    return p;
  endfunction

  task automatic add_random(int n);
    repeat (n) pose_q.push_back(rnd_pose());
  endtask

  task automatic random_config();
    write_reg(CFG_PROP_GAIN, 16'($urandom_range(0, 1023)));
    write_reg(CFG_DERIV_GAIN, 16'($urandom_range(0, 1023)));
    write_reg(CFG_WHEEL_RADIUS, 16'($urandom_range(1, 8191)));
    write_reg(CFG_WHEEL_BASE, 16'($urandom_range(1, 8191)));
    write_reg(CFG_POINT_OFFSET, 16'($urandom_range(1, 8191)));
    write_reg(CFG_SAMPLE_RATE, 16'($urandom_range(1, 10000)));
    write_reg(CFG_SPEED_LIMIT, 16'($urandom_range(0, 32767)));
  endtask

  initial begin
    pose_t p;
    send_idle_pct = 8; recv_idle_pct = 81; send_pause = 0;
    rst_n = 0;
    cfg_we = 0; cfg_index = CFG_PROP_GAIN; cfg_data = '0;
    kp = 128; kd = 128; rad = 410; base = 2048; poff = 410;
    rate = 100; slim = 12288; prev_ex = 0; prev_ey = 0;
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n = 1;

    // directed: field extremes, both angle signs, quarter turns
    p = '0; pose_q.push_back(p);
    p = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF};
    pose_q.push_back(p);
    p = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000};
    pose_q.push_back(p);
    p = '{16'h7FFF, 16'h8000, 16'h4000, 16'h8000, 16'h7FFF, 16'hC000, 16'h7FFF, 16'h8000};
    pose_q.push_back(p);
    p = '{16'h0100, 16'hFF00, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0100, 16'h0000};
    pose_q.push_back(p);
    p = '{16'hFFFF, 16'h0001, 16'h003F, 16'h0001, 16'hFFFF, 16'h0040, 16'h0001, 16'hFFFF};
    pose_q.push_back(p);
    wait_drained();

    // extremes: huge gains (u saturation), zero radius/offset, zero rate/limit
    write_reg(CFG_PROP_GAIN, 16'hFFFF);
    write_reg(CFG_DERIV_GAIN, 16'hFFFF);
    write_reg(CFG_WHEEL_RADIUS, 16'h0000);
    write_reg(CFG_POINT_OFFSET, 16'h0000);
    write_reg(CFG_SAMPLE_RATE, 16'd10000);
    write_reg(CFG_SPEED_LIMIT, 16'h7FFF);
    write_reg(CFG_WHEEL_BASE, 16'hFFFF);
    add_random(8);
    wait_drained();
    write_reg(CFG_SAMPLE_RATE, 16'h0000);
    write_reg(CFG_SPEED_LIMIT, 16'h0000);
    write_reg(CFG_WHEEL_BASE, 16'h0001);
    add_random(6);
    wait_drained();
    write_reg(CFG_PROP_GAIN, 16'h0000);
    write_reg(CFG_DERIV_GAIN, 16'h0000);
    write_reg(CFG_WHEEL_RADIUS, 16'hFFFF);
    write_reg(CFG_POINT_OFFSET, 16'hFFFF);
    write_reg(CFG_SAMPLE_RATE, 16'hFFFF);
    write_reg(CFG_SPEED_LIMIT, 16'd12288);
    add_random(5);
    wait_drained();

    // defaults-like setting, then random settings
    write_reg(CFG_PROP_GAIN, 16'd128);
    write_reg(CFG_DERIV_GAIN, 16'd128);
    write_reg(CFG_WHEEL_RADIUS, 16'd410);
    write_reg(CFG_WHEEL_BASE, 16'd2048);
    write_reg(CFG_POINT_OFFSET, 16'd410);
    write_reg(CFG_SAMPLE_RATE, 16'd100);
    write_reg(CFG_SPEED_LIMIT, 16'd12288);
    add_random(150);
    // long receiver hold while the sender keeps offering
    hold_req = ~hold_req;
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin send_idle_pct = 81; recv_idle_pct = 8; end
      if (ph == 4) begin send_idle_pct = 0; recv_idle_pct = 0; end
      random_config();
      add_random(95);
      // sender pause until everything is back, then resume
      while (pose_q.size() > 50) @(posedge clk);
      send_pause = 1;
      while (in_valid || cmd_q.size() != 0) @(posedge clk);
      send_pause = 0;
      add_random(95);
      wait_drained();
    end

    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

// ----- filelist.f -----
src/fpdc_pkg.sv
src/fpdc_div.sv
src/formation_pd_wheel_speed_controller.sv
tb/formation_pd_wheel_speed_controller_tb.sv
